// ===== sv/mbrf_pkg.sv =====
// ----------------------------------------------------------------------------
// mbrf_pkg
// Shared types and constants of the monochrome bitmap rectangle fill core.
// ----------------------------------------------------------------------------
package mbrf_pkg;

    // Field widths of the item, result and configuration ports.
    localparam int OP_W       = 2;
    localparam int COORD_W    = 10;
    localparam int SIZE_W     = 11;
    localparam int WIDX_W     = 12;
    localparam int WORD_W     = 32;
    localparam int WID_REG_W  = 10;
    localparam int HGT_REG_W  = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int PIX_SHIFT  = 5;

    localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [PIX_SHIFT-1:0] LAST_PIX = 5'd31;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_FILL  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

    localparam int WID_RESET = 512;
    localparam int HGT_RESET = 256;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_DRAIN,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic clr_write;
        logic latch;
        logic exec;
        logic fill_issue;
        logic res_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic fill_go;
        logic fill_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== sv/mbrf_ram.sv =====
// ----------------------------------------------------------------------------
// mbrf_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mbrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/mbrf_datapath.sv =====
// ----------------------------------------------------------------------------
// mbrf_datapath
// Configuration registers, item capture, fill clipping and address walk,
// read-modify-write stage, frame store and output register.
// ----------------------------------------------------------------------------
module mbrf_datapath #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mbrf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mbrf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [mbrf_pkg::OP_W-1:0]            i_operation,
    input  logic [mbrf_pkg::COORD_W-1:0]         i_rect_x,
    input  logic [mbrf_pkg::COORD_W-1:0]         i_rect_y,
    input  logic [mbrf_pkg::SIZE_W-1:0]          i_rect_w,
    input  logic [mbrf_pkg::SIZE_W-1:0]          i_rect_h,
    input  logic                                 i_set_pixels,
    input  logic [mbrf_pkg::WIDX_W-1:0]          i_word_index,
    input  logic [mbrf_pkg::WORD_W-1:0]          i_word_data,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic [mbrf_pkg::WORD_W-1:0]          o_read_data,
    output logic                                 o_drawn,
    input  mbrf_pkg::t_dp_cmd                    i_cmd,
    output mbrf_pkg::t_dp_sts                    o_sts
);
    import mbrf_pkg::*;

    localparam int WPR         = (MAX_WIDTH + WORD_W - 1) / WORD_W;
    localparam int STORE_WORDS = WPR * MAX_HEIGHT;
    localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int CW          = (WPR > 1) ? $clog2(WPR) : 1;
    localparam logic [WID_REG_W-1:0] WID_RST =
        (WID_RESET > MAX_WIDTH) ? WID_REG_W'(MAX_WIDTH) : WID_REG_W'(WID_RESET);
    localparam logic [HGT_REG_W-1:0] HGT_RST =
        (HGT_RESET > MAX_HEIGHT) ? HGT_REG_W'(MAX_HEIGHT) : HGT_REG_W'(HGT_RESET);

    // Effective (clamped) bitmap size.
    logic [WID_REG_W-1:0] r_wid;
    logic [HGT_REG_W-1:0] r_hgt;

    // Captured item.
    logic [OP_W-1:0]    r_op;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [SIZE_W-1:0]  r_w;
    logic [SIZE_W-1:0]  r_h;
    logic               r_set;
    logic               r_idx_ok;
    logic [AW-1:0]      r_addr_in;
    logic [WORD_W-1:0]  r_wdata;

    // Fill walk.
    logic [HGT_REG_W-1:0] r_row;
    logic [HGT_REG_W-1:0] r_last_row;
    logic [CW-1:0]        r_col;
    logic [CW-1:0]        r_first_col;
    logic [CW-1:0]        r_last_col;
    logic [PIX_SHIFT-1:0] r_lo;
    logic [PIX_SHIFT-1:0] r_hi_last;
    logic [AW-1:0]        r_row_base;
    logic                 r_drawn;

    // Write-back stage of the read-modify-write.
    logic               r_wb_valid;
    logic [AW-1:0]      r_wb_addr;
    logic [WORD_W-1:0]  r_wb_mask;

    logic [AW-1:0]      r_clr_addr;

    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_data;
    logic               r_out_drawn;

    // Clipping of the captured rectangle.
    logic                 x_ok;
    logic                 y_ok;
    logic                 empty;
    logic [SIZE_W-1:0]    span_w;
    logic [SIZE_W-1:0]    w_eff;
    logic [SIZE_W-1:0]    last_x_ext;
    logic [SIZE_W-1:0]    span_h;
    logic [SIZE_W-1:0]    h_eff;
    logic [SIZE_W-1:0]    last_y_ext;
    logic [AW-1:0]        row_base0;

    // Current fill word.
    logic [PIX_SHIFT-1:0] lo;
    logic [PIX_SHIFT-1:0] hi;
    logic [WORD_W-1:0]    mask;
    logic [AW-1:0]        fill_addr;
    logic                 col_last;

    // Frame store ports.
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wid <= WID_RST;
            r_hgt <= HGT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_WIDTH) begin
                if (int'(i_cfg_data[WID_REG_W-1:0]) > MAX_WIDTH) begin
                    r_wid <= WID_REG_W'(MAX_WIDTH);
                end else begin
                    r_wid <= i_cfg_data[WID_REG_W-1:0];
                end
            end else if (i_cfg_index == CFG_HEIGHT) begin
                if (int'(i_cfg_data[HGT_REG_W-1:0]) > MAX_HEIGHT) begin
                    r_hgt <= HGT_REG_W'(MAX_HEIGHT);
                end else begin
                    r_hgt <= i_cfg_data[HGT_REG_W-1:0];
                end
            end
        end
    end

    always_comb begin
        x_ok       = r_x < r_wid;
        y_ok       = r_y < {1'b0, r_hgt};
        empty      = !x_ok || !y_ok || (r_w == '0) || (r_h == '0);
        span_w     = {1'b0, r_wid} - {1'b0, r_x};
        w_eff      = (r_w > span_w) ? span_w : r_w;
        last_x_ext = {1'b0, r_x} + w_eff - SIZE_W'(1);
        span_h     = {2'b00, r_hgt} - {1'b0, r_y};
        h_eff      = (r_h > span_h) ? span_h : r_h;
        last_y_ext = {1'b0, r_y} + h_eff - SIZE_W'(1);
        row_base0  = AW'(int'(r_y[HGT_REG_W-1:0]) * WPR);
    end

    always_comb begin
        col_last  = r_col == r_last_col;
        lo        = (r_col == r_first_col) ? r_lo : '0;
        hi        = col_last ? r_hi_last : LAST_PIX;
        mask      = (ALL_ONES >> lo) & (ALL_ONES << (LAST_PIX - hi));
        fill_addr = r_row_base + AW'(r_col);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op      <= i_operation;
            r_x       <= i_rect_x;
            r_y       <= i_rect_y;
            r_w       <= i_rect_w;
            r_h       <= i_rect_h;
            r_set     <= i_set_pixels;
            r_idx_ok  <= int'(i_word_index) < STORE_WORDS;
            r_addr_in <= AW'(i_word_index);
            r_wdata   <= i_word_data;
        end
        if (i_cmd.exec) begin
            r_drawn     <= (r_op == OP_FILL) && !empty;
            r_row       <= r_y[HGT_REG_W-1:0];
            r_last_row  <= last_y_ext[HGT_REG_W-1:0];
            r_first_col <= CW'(r_x >> PIX_SHIFT);
            r_col       <= CW'(r_x >> PIX_SHIFT);
            r_last_col  <= CW'(last_x_ext[COORD_W-1:0] >> PIX_SHIFT);
            r_lo        <= r_x[PIX_SHIFT-1:0];
            r_hi_last   <= last_x_ext[PIX_SHIFT-1:0];
            r_row_base  <= row_base0;
        end else if (i_cmd.fill_issue) begin
            if (col_last) begin
                r_col      <= r_first_col;
                r_row      <= r_row + HGT_REG_W'(1);
                r_row_base <= r_row_base + AW'(WPR);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
        if (i_cmd.fill_issue) begin
            r_wb_addr <= fill_addr;
            r_wb_mask <= mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_valid <= 1'b0;
            r_clr_addr <= '0;
        end else begin
            r_wb_valid <= i_cmd.fill_issue;
            if (i_cmd.clr_write) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_comb begin
        ram_we = i_cmd.clr_write || r_wb_valid
              || (i_cmd.exec && (r_op == OP_WRITE) && r_idx_ok);
        priority if (i_cmd.clr_write) begin
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (r_wb_valid) begin
            ram_waddr = r_wb_addr;
            ram_wdata = r_set ? (ram_rdata | r_wb_mask) : (ram_rdata & ~r_wb_mask);
        end else begin
            ram_waddr = r_addr_in;
            ram_wdata = r_wdata;
        end
        ram_re    = i_cmd.fill_issue || (i_cmd.exec && (r_op == OP_READ) && r_idx_ok);
        ram_raddr = i_cmd.fill_issue ? fill_addr : r_addr_in;
    end

    mbrf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The read data waits in the RAM output register until res_load copies it out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.res_load) begin
            r_out_data  <= ((r_op == OP_READ) && r_idx_ok) ? ram_rdata : '0;
            r_out_drawn <= r_drawn;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_drawn     = r_out_drawn;

    always_comb begin
        o_sts.clr_done  = r_clr_addr == AW'(STORE_WORDS - 1);
        o_sts.fill_go   = (r_op == OP_FILL) && !empty;
        o_sts.fill_last = col_last && (r_row == r_last_row);
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

endmodule

// ===== sv/mbrf_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbrf_ctrl
// Sequencer of the fill core: store clearing, item capture, execution,
// fill word walk and result handoff.
// ----------------------------------------------------------------------------
module mbrf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mbrf_pkg::t_dp_sts i_sts,
    output mbrf_pkg::t_dp_cmd o_cmd
);
    import mbrf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.fill_go ? ST_FILL : ST_RESP;
            end
            ST_FILL: begin
                o_cmd.fill_issue = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The last word of the fill is written back in this cycle.
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/mono_bitmap_rect_fill_core.sv =====
// ----------------------------------------------------------------------------
// mono_bitmap_rect_fill_core
// One-bit-per-pixel frame store with word read, word write and clipped
// rectangle fill.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one operation per
//   transaction; every transaction returns exactly one result on the output
//   channel (o_out_valid / i_out_stall). The configuration channel
//   (i_cfg_valid / o_cfg_ready) is always ready and sets the bitmap width
//   (index 0) and height (index 1); write it only while the core is idle.
//   Word read or write: the core captures the item, executes it and loads
//   the result into the output register. Fill: one word per cycle between
//   execute and handoff through a pipelined read-modify-write on the store's
//   single write port; an empty fill skips the walk.
//   After reset the core clears the frame store one word per cycle,
//   all WORDS_PER_ROW * MAX_HEIGHT words (4096 at the defaults), with the input
//   stalled; configuration writes are taken during the clearing pass.
//   A result waits in the output register while the receiver stalls; the
//   core accepts and works on the next transaction meanwhile and holds that
//   one's result until the output register frees up.
// ----------------------------------------------------------------------------
module mono_bitmap_rect_fill_core #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mbrf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mbrf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [mbrf_pkg::OP_W-1:0]       i_operation,
    input  logic [mbrf_pkg::COORD_W-1:0]    i_rect_x,
    input  logic [mbrf_pkg::COORD_W-1:0]    i_rect_y,
    input  logic [mbrf_pkg::SIZE_W-1:0]     i_rect_w,
    input  logic [mbrf_pkg::SIZE_W-1:0]     i_rect_h,
    input  logic                            i_set_pixels,
    input  logic [mbrf_pkg::WIDX_W-1:0]     i_word_index,
    input  logic [mbrf_pkg::WORD_W-1:0]     i_word_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [mbrf_pkg::WORD_W-1:0]     o_read_data,
    output logic                            o_drawn
);
    import mbrf_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    mbrf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mbrf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_operation  (i_operation),
        .i_rect_x     (i_rect_x),
        .i_rect_y     (i_rect_y),
        .i_rect_w     (i_rect_w),
        .i_rect_h     (i_rect_h),
        .i_set_pixels (i_set_pixels),
        .i_word_index (i_word_index),
        .i_word_data  (i_word_data),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_read_data  (o_read_data),
        .o_drawn      (o_drawn),
        .i_cmd        (cmd),
        .o_sts        (sts)
    );

    // A new result never overwrites one the receiver has not yet taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.res_load |-> !(o_out_valid && i_out_stall))
        else $error("result loaded over a stalled output");

    // The sequencer drives at most one datapath action per cycle.
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clr_write, cmd.latch, cmd.exec, cmd.fill_issue, cmd.res_load}))
        else $error("more than one datapath action in a cycle");

    // A captured transaction is executed in the following cycle.
    a_exec_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.latch |=> cmd.exec)
        else $error("captured transaction not executed");

    // The fill walk stops after its last word.
    a_fill_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.fill_issue && sts.fill_last) |=> !cmd.fill_issue)
        else $error("fill walk ran past its last word");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the monochrome bitmap rectangle fill core. A short
// table of directed operations covers empty, clipped, full-screen and
// single-pixel fills plus word access at the store's ends. Random operations
// then run under several bitmap sizes. A shadow frame store predicts every
// result, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import mbrf_pkg::*;

    localparam int MAX_W         = 512;
    localparam int MAX_H         = 256;
    localparam int WORDS_PER_ROW = (MAX_W + 31) / 32;
    localparam int STORE_WORDS   = WORDS_PER_ROW * MAX_H;

    localparam logic [OP_W-1:0]      OP_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam int N_DIRECTED    = 25;
    localparam int N_PHASES      = 7;
    localparam int RANDOM_PHASE  = 5;
    localparam int HOLD_PHASE    = 3;
    localparam int PAUSE_PHASE   = 5;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 20000;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SIZE_W-1:0]  w;
        logic [SIZE_W-1:0]  h;
        logic               set;
        logic [WIDX_W-1:0]  idx;
        logic [WORD_W-1:0]  data;
    } t_item;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              drawn;
    } t_result;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SIZE_W-1:0]  w;
        logic [SIZE_W-1:0]  h;
        logic               set;
        logic [WIDX_W-1:0]  idx;
        logic [WORD_W-1:0]  data;
        logic               typed;
        logic [WORD_W-1:0]  want_data;
        logic               want_drawn;
    } t_row;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [OP_W-1:0]       i_operation;
    logic [COORD_W-1:0]    i_rect_x;
    logic [COORD_W-1:0]    i_rect_y;
    logic [SIZE_W-1:0]     i_rect_w;
    logic [SIZE_W-1:0]     i_rect_h;
    logic                  i_set_pixels;
    logic [WIDX_W-1:0]     i_word_index;
    logic [WORD_W-1:0]     i_word_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [WORD_W-1:0]     o_read_data;
    logic                  o_drawn;

    logic [WORD_W-1:0] shadow_frame [STORE_WORDS];
    int                shadow_width;
    int                shadow_height;
    t_result           expected_results [$];
    int                mismatch_count = 0;
    int                burst_left = 0;
    int                hold_requests = 0;

    int phase_width  [N_PHASES] = '{1023, 1, 0, 100, 33, 0, 512};
    int phase_height [N_PHASES] = '{1023, 1, 0, 37, 256, 0, 256};
    int phase_items  [N_PHASES] = '{70, 50, 30, 70, 70, 80, 80};

    // Rows with typed set carry their own expected result; the rest are
    // checked against the shadow store.
    t_row directed_rows [N_DIRECTED] = '{
        '{OP_READ,   10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 12'd0,    32'h0,
          1'b1, 32'h0000_0000, 1'b0},
        '{OP_READ,   10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 12'd4095, 32'h0,
          1'b1, 32'h0000_0000, 1'b0},
        '{OP_WRITE,  10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 12'd0,    32'hFFFF_FFFF,
          1'b1, 32'h0000_0000, 1'b0},
        '{OP_READ,   10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 12'd0,    32'h0,
          1'b1, 32'hFFFF_FFFF, 1'b0},
        '{OP_WRITE,  10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 12'd4095, 32'h8000_0001,
          1'b1, 32'h0000_0000, 1'b0},
        '{OP_READ,   10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 12'd4095, 32'h0,
          1'b1, 32'h8000_0001, 1'b0},
        '{OP_UNUSED, 10'd1023, 10'd1023, 11'd1024, 11'd1024, 1'b1, 12'd0,    32'h0,
          1'b1, 32'h0000_0000, 1'b0},
        '{OP_READ,   10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 12'd0,    32'h0,
          1'b1, 32'hFFFF_FFFF, 1'b0},
        '{OP_FILL,   10'd0,    10'd0,    11'd1024, 11'd1024, 1'b1, 12'd0,    32'h0,
          1'b1, 32'h0000_0000, 1'b1},
        '{OP_READ,   10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 12'd2000, 32'h0,
          1'b1, 32'hFFFF_FFFF, 1'b0},
        '{OP_FILL,   10'd512,  10'd0,    11'd5,    11'd5,    1'b0, 12'd0,    32'h0,
          1'b1, 32'h0000_0000, 1'b0},
        '{OP_FILL,   10'd0,    10'd256,  11'd5,    11'd5,    1'b0, 12'd0,    32'h0,
          1'b1, 32'h0000_0000, 1'b0},
        '{OP_FILL,   10'd1023, 10'd1023, 11'd1024, 11'd1024, 1'b0, 12'd0,    32'h0,
          1'b1, 32'h0000_0000, 1'b0},
        '{OP_FILL,   10'd0,    10'd0,    11'd0,    11'd5,    1'b0, 12'd0,    32'h0,
          1'b1, 32'h0000_0000, 1'b0},
        '{OP_FILL,   10'd0,    10'd0,    11'd5,    11'd0,    1'b0, 12'd0,    32'h0,
          1'b1, 32'h0000_0000, 1'b0},
        '{OP_READ,   10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 12'd0,    32'h0,
          1'b1, 32'hFFFF_FFFF, 1'b0},
        '{OP_FILL,   10'd3,    10'd1,    11'd10,   11'd2,    1'b0, 12'd0,    32'h0,
          1'b0, 32'h0, 1'b0},
        '{OP_READ,   10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 12'd16,   32'h0,
          1'b0, 32'h0, 1'b0},
        '{OP_FILL,   10'd30,   10'd5,    11'd4,    11'd1,    1'b0, 12'd0,    32'h0,
          1'b0, 32'h0, 1'b0},
        '{OP_READ,   10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 12'd80,   32'h0,
          1'b0, 32'h0, 1'b0},
        '{OP_READ,   10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 12'd81,   32'h0,
          1'b0, 32'h0, 1'b0},
        '{OP_FILL,   10'd511,  10'd255,  11'd1,    11'd1,    1'b0, 12'd0,    32'h0,
          1'b0, 32'h0, 1'b0},
        '{OP_READ,   10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 12'd4095, 32'h0,
          1'b0, 32'h0, 1'b0},
        '{OP_FILL,   10'd0,    10'd0,    11'd1024, 11'd1024, 1'b0, 12'd0,    32'h0,
          1'b1, 32'h0000_0000, 1'b1},
        '{OP_READ,   10'd0,    10'd0,    11'd0,    11'd0,    1'b0, 12'd4095, 32'h0,
          1'b1, 32'h0000_0000, 1'b0}
    };

    mono_bitmap_rect_fill_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_rect_x     (i_rect_x),
        .i_rect_y     (i_rect_y),
        .i_rect_w     (i_rect_w),
        .i_rect_h     (i_rect_h),
        .i_set_pixels (i_set_pixels),
        .i_word_index (i_word_index),
        .i_word_data  (i_word_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_data  (o_read_data),
        .o_drawn      (o_drawn)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Applies one operation to the shadow store and returns its result.
    function automatic t_result apply_item(t_item it);
        t_result           res;
        int                wid, hgt, x, y, w, h, last, c_first, c_last;
        int                r, c, lo, hi, addr;
        logic [WORD_W-1:0] mask;
        res = '0;
        case (it.op)
            OP_READ: begin
                if (int'(it.idx) < STORE_WORDS) res.read_data = shadow_frame[it.idx];
            end
            OP_WRITE: begin
                if (int'(it.idx) < STORE_WORDS) shadow_frame[it.idx] = it.data;
            end
            OP_FILL: begin
                wid = (shadow_width > MAX_W) ? MAX_W : shadow_width;
                hgt = (shadow_height > MAX_H) ? MAX_H : shadow_height;
                x = int'(it.x);
                y = int'(it.y);
                w = int'(it.w);
                h = int'(it.h);
                if (x < wid && y < hgt && w != 0 && h != 0) begin
                    if (w > wid - x) w = wid - x;
                    if (h > hgt - y) h = hgt - y;
                    last = x + w - 1;
                    c_first = x >> PIX_SHIFT;
                    c_last = last >> PIX_SHIFT;
                    for (r = y; r < y + h; r++) begin
                        for (c = c_first; c <= c_last; c++) begin
                            lo = (c == c_first) ? (x & int'(LAST_PIX)) : 0;
                            hi = (c == c_last) ? (last & int'(LAST_PIX)) : int'(LAST_PIX);
                            mask = (ALL_ONES >> lo) & (ALL_ONES << (int'(LAST_PIX) - hi));
                            addr = r * WORDS_PER_ROW + c;
                            if (addr < STORE_WORDS) begin
                                if (it.set) shadow_frame[addr] = shadow_frame[addr] | mask;
                                else shadow_frame[addr] = shadow_frame[addr] & ~mask;
                            end
                        end
                    end
                    res.drawn = 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Mostly small rectangles inside the bitmap in use, a few huge or
    // misplaced ones, and word accesses biased toward the rows in use.
    function automatic t_item random_item();
        t_item it;
        int    wid, hgt, pick;
        wid = (shadow_width > MAX_W) ? MAX_W : shadow_width;
        hgt = (shadow_height > MAX_H) ? MAX_H : shadow_height;
        if (wid < 1) wid = 1;
        if (hgt < 1) hgt = 1;
        pick = $urandom_range(0, 19);
        if (pick < 6) it.op = OP_READ;
        else if (pick < 11) it.op = OP_WRITE;
        else if (pick < 19) it.op = OP_FILL;
        else it.op = OP_UNUSED;
        it.x = COORD_W'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, wid - 1));
        it.y = COORD_W'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, hgt - 1));
        pick = $urandom_range(0, 19);
        if (pick < 14) it.w = SIZE_W'($urandom_range(0, 40));
        else if (pick < 18) it.w = SIZE_W'($urandom_range(0, wid));
        else if (pick == 18) it.w = SIZE_W'(1024);
        else it.w = SIZE_W'($urandom_range(0, 1023));
        pick = $urandom_range(0, 19);
        if (pick < 16) it.h = SIZE_W'($urandom_range(0, 6));
        else if (pick < 19) it.h = SIZE_W'($urandom_range(0, hgt));
        else it.h = SIZE_W'(1024);
        it.set = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) < 3)
            it.idx = WIDX_W'($urandom_range(0, hgt - 1) * WORDS_PER_ROW
                             + $urandom_range(0, WORDS_PER_ROW - 1));
        else
            it.idx = WIDX_W'($urandom_range(0, STORE_WORDS - 1));
        it.data = $urandom();
        return it;
    endfunction

    task automatic offer(input t_item it, input logic typed, input t_result want);
        t_result predicted;
        int      gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_operation  <= it.op;
        i_rect_x     <= it.x;
        i_rect_y     <= it.y;
        i_rect_w     <= it.w;
        i_rect_h     <= it.h;
        i_set_pixels <= it.set;
        i_word_index <= it.idx;
        i_word_data  <= it.data;
        do @(posedge i_clk); while (o_in_stall);
        predicted = apply_item(it);
        expected_results.push_back(typed ? want : predicted);
        burst_left--;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == CFG_WIDTH) shadow_width = int'(value);
        else if (index == CFG_HEIGHT) shadow_height = int'(value[HGT_REG_W-1:0]);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with no transaction outstanding: read_data %h drawn %b",
                       o_read_data, o_drawn);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_read_data !== want.read_data) begin
                    $error("read_data mismatch: expected %h, actual %h",
                           want.read_data, o_read_data);
                    mismatch_count++;
                end
                if (o_drawn !== want.drawn) begin
                    $error("drawn mismatch: expected %b, actual %b", want.drawn, o_drawn);
                    mismatch_count++;
                end
            end
        end
    end

    // The receiver changes its stall behavior at random intervals and
    // takes a long hold-off whenever one is requested.
    initial begin : output_side
        int          seg_left, hold_left, holds_done;
        t_stall_mode mode;
        logic        stall;
        seg_left = 0;
        hold_left = 0;
        holds_done = 0;
        mode = STALL_NONE;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && holds_done < hold_requests) begin
                holds_done++;
                hold_left = LONG_HOLD;
            end
            if (seg_left == 0) begin
                mode = t_stall_mode'($urandom_range(0, 3));
                seg_left = $urandom_range(10, 150);
            end
            seg_left--;
            if (hold_left > 0) begin
                hold_left--;
                stall = 1'b1;
            end else begin
                case (mode)
                    STALL_NONE:   stall = 1'b0;
                    STALL_LIGHT:  stall = ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:  stall = ($urandom_range(0, 3) != 0);
                    default:      stall = !i_out_stall;
                endcase
            end
            i_out_stall <= stall;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        t_item   it;
        t_result none;
        int      i, p, n;
        none = '0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_operation = OP_READ;
        i_rect_x = '0;
        i_rect_y = '0;
        i_rect_w = '0;
        i_rect_h = '0;
        i_set_pixels = 1'b0;
        i_word_index = '0;
        i_word_data = '0;
        for (i = 0; i < STORE_WORDS; i++) shadow_frame[i] = '0;
        shadow_width = WID_RESET;
        shadow_height = HGT_RESET;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++) begin
            it.op   = directed_rows[i].op;
            it.x    = directed_rows[i].x;
            it.y    = directed_rows[i].y;
            it.w    = directed_rows[i].w;
            it.h    = directed_rows[i].h;
            it.set  = directed_rows[i].set;
            it.idx  = directed_rows[i].idx;
            it.data = directed_rows[i].data;
            offer(it, directed_rows[i].typed,
                  '{directed_rows[i].want_data, directed_rows[i].want_drawn});
        end
        drain();

        phase_width[RANDOM_PHASE] = $urandom_range(1, MAX_W);
        phase_height[RANDOM_PHASE] = $urandom_range(1, MAX_H);
        for (p = 0; p < N_PHASES; p++) begin
            write_reg(CFG_WIDTH, CFG_DATA_W'(phase_width[p]));
            write_reg(CFG_HEIGHT, CFG_DATA_W'(phase_height[p]));
            // Writes to the unused indexes must leave both sizes alone.
            write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom()));
            write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom()));
            for (n = 0; n < phase_items[p]; n++) begin
                if (p == HOLD_PHASE && n == 10) hold_requests++;
                if (p == PAUSE_PHASE && n == 40) drain();
                offer(random_item(), 1'b0, none);
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/mbrf_pkg.sv
sv/mbrf_ram.sv
sv/mbrf_datapath.sv
sv/mbrf_ctrl.sv
sv/mono_bitmap_rect_fill_core.sv
test/tb_top.sv
